### rtl/core/mvp_pkg.sv
// Shared constants and codes for the move velocity profile block.
`timescale 1ns / 1ps

package mvp_pkg;

  // Fixed-point format of positions, speeds and distances
  localparam int FRAC_BITS = 16;

  // Field widths
  localparam int POS_W      = 32;
  localparam int DRIVE_W    = 16;
  localparam int SPEED_W    = 21;
  localparam int DIST_W     = 31;
  localparam int ANGLE_W    = 24;
  localparam int ACCEL_W    = 25;
  localparam int TICK_W     = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE        = 3'd0,
    CFG_CRUISE      = 3'd1,
    CFG_TARGET      = 3'd2,
    CFG_ANGLE       = 3'd3,
    CFG_SEPARATION  = 3'd4,
    CFG_MAX_ACCEL   = 3'd5,
    CFG_ACCEL_TICK  = 3'd6,
    CFG_MIN_SPEED   = 3'd7
  } cfg_idx_t;

  // Move modes
  localparam logic MODE_STRAIGHT = 1'b0;
  localparam logic MODE_SPIN     = 1'b1;

  // Travel and remaining distance
  localparam int TRAVEL_W   = POS_W + 1;   // signed travel since start
  localparam int WIDE_W     = POS_W + 3;   // signed remaining before clamp
  localparam int REM_W      = POS_W + 1;   // positive remaining distance

  // Shared multiplier
  localparam int MUL_A_W    = ACCEL_W;
  localparam int MUL_B_W    = REM_W;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;

  // Square root unit
  localparam int SQ_IN_W    = PROD_W + 2;
  localparam int SQ_ROOT_W  = SQ_IN_W / 2;
  localparam int SQ_CNT_W   = $clog2(SQ_ROOT_W);

  // Drive scaling
  localparam int SCALE_W    = 7;
  localparam logic [SCALE_W-1:0] DRIVE_SCALE = 7'd100;
  localparam int DRV_PROD_W = SPEED_W + SCALE_W;
  localparam logic [DRV_PROD_W-1:0] DRIVE_MAX = DRV_PROD_W'(32767);

endpackage

### rtl/core/mvp_ifs.sv
// Valid/ready channel interfaces for position requests and drive results.
`timescale 1ns / 1ps

interface mvp_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [mvp_pkg::POS_W-1:0]    left_position;
  logic signed [mvp_pkg::POS_W-1:0]    right_position;
  logic                                start_req;
  logic                                stop_request;

  modport source (
    output valid, left_position, right_position, start_req, stop_request,
    input  ready
  );
  modport sink (
    input  valid, left_position, right_position, start_req, stop_request,
    output ready
  );
endinterface

interface mvp_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [mvp_pkg::DRIVE_W-1:0]  left_drive;
  logic signed [mvp_pkg::DRIVE_W-1:0]  right_drive;
  logic                                done_res;

  modport source (
    output valid, left_drive, right_drive, done_res,
    input  ready
  );
  modport sink (
    input  valid, left_drive, right_drive, done_res,
    output ready
  );
endinterface

### rtl/core/mvp_isqrt.sv
// Iterative floor square root, two radicand bits per cycle.
`timescale 1ns / 1ps

module mvp_isqrt (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [mvp_pkg::SQ_IN_W-1:0]     radicand,
  output logic                            done,
  output logic [mvp_pkg::SQ_ROOT_W-1:0]   root
);

  localparam int RW = mvp_pkg::SQ_ROOT_W;

  logic [mvp_pkg::SQ_IN_W-1:0]  rad_r;
  logic [RW+1:0]                rem_r;
  logic [RW-1:0]                root_r;
  logic [mvp_pkg::SQ_CNT_W-1:0] cnt_r;
  logic                         busy_r;
  logic                         done_r;

  logic [RW+3:0] rem_sh;
  logic [RW+3:0] trial;
  logic [RW+3:0] diff;
  logic          fits;

  // one restoring step: bring down two bits, try (4*root + 1)
  assign rem_sh = {rem_r, rad_r[mvp_pkg::SQ_IN_W-1 -: 2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign diff   = rem_sh - trial;
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rad_r  <= '0;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rad_r  <= {rad_r[mvp_pkg::SQ_IN_W-3:0], 2'b00};
        rem_r  <= fits ? diff[RW+1:0] : rem_sh[RW+1:0];
        root_r <= {root_r[RW-2:0], fits};
        if (cnt_r == mvp_pkg::SQ_CNT_W'(RW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          cnt_r  <= '0;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

  // counter rests at zero between roots
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> cnt_r == '0)
    else $error("isqrt counter not cleared while idle");

  // done pulses only at the end of a busy run
  a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> $past(busy_r))
    else $error("isqrt done without a run");

  // done is a single-cycle pulse
  a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("isqrt done held longer than one cycle");

endmodule

### rtl/core/move_velocity_profile.sv
// Top level: trapezoidal velocity profile for a two-wheeled base.
// A moving tick runs the measure, travel, target, remaining, multiply (MULQ, MULA),
//   square root, min, drive and output states; a tick that ends the move goes from the
//   remaining state to output, and an idle tick from the travel state to output. The
//   30-step square root unit is the longest part of a moving tick.
// A new request is taken as soon as the result is loaded, even if it waits for out ready.
// Reset (synchronous, rst_n low) clears all registers, the move state and the channels.
`timescale 1ns / 1ps

module move_velocity_profile (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mvp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mvp_pkg::CFG_DATA_W-1:0]    cfg_data,
  mvp_in_if.sink                            in_if,
  mvp_out_if.source                         out_if
);

  typedef enum logic [3:0] {
    S_IDLE, S_MEAS, S_TRAV, S_TGT, S_REM, S_MULQ, S_MULA, S_SQRT,
    S_MIN, S_DRV, S_OUT
  } state_t;

  // configuration registers
  logic                                 mode_r;
  logic [mvp_pkg::SPEED_W-1:0]          cruise_r;
  logic [mvp_pkg::DIST_W-1:0]           target_r;
  logic signed [mvp_pkg::ANGLE_W-1:0]   angle_r;
  logic [mvp_pkg::SPEED_W-1:0]          sep_r;
  logic [mvp_pkg::ACCEL_W-1:0]          max_accel_r;
  logic [mvp_pkg::SPEED_W-1:0]          accel_tick_r;
  logic [mvp_pkg::SPEED_W-1:0]          speed_floor_r;

  // move state
  logic signed [mvp_pkg::POS_W-1:0]     start_pos_r;
  logic [mvp_pkg::TICK_W-1:0]           tick_r;
  logic                                 moving_r;

  // working registers
  state_t                               state_r;
  logic signed [mvp_pkg::POS_W-1:0]     left_r;
  logic signed [mvp_pkg::POS_W-1:0]     right_r;
  logic                                 start_r;
  logic                                 stop_r;
  logic signed [mvp_pkg::POS_W-1:0]     meas_r;
  logic signed [mvp_pkg::TRAVEL_W-1:0]  travel_r;
  logic [mvp_pkg::REM_W-1:0]            rem_r;
  logic [mvp_pkg::PROD_W-1:0]           prod_r;
  logic [mvp_pkg::SPEED_W-1:0]          speed_r;
  logic signed [mvp_pkg::DRIVE_W-1:0]   pend_left_r;
  logic signed [mvp_pkg::DRIVE_W-1:0]   pend_right_r;
  logic                                 pend_done_r;

  // result register
  logic                                 out_valid_r;
  logic signed [mvp_pkg::DRIVE_W-1:0]   out_left_r;
  logic signed [mvp_pkg::DRIVE_W-1:0]   out_right_r;
  logic                                 out_done_r;

  // combinational helpers
  logic signed [mvp_pkg::POS_W:0]       pos_sum;
  logic signed [mvp_pkg::POS_W-1:0]     meas_val;
  logic [mvp_pkg::ANGLE_W-1:0]          angle_abs;
  logic [mvp_pkg::MUL_A_W-1:0]          mul_a;
  logic [mvp_pkg::MUL_B_W-1:0]          mul_b;
  logic signed [mvp_pkg::WIDE_W-1:0]    target_val;
  logic signed [mvp_pkg::WIDE_W-1:0]    rem_val;
  logic                                 finish;
  logic                                 sq_start;
  logic                                 sq_done;
  logic [mvp_pkg::SQ_ROOT_W-1:0]        sq_root;
  logic [mvp_pkg::SQ_ROOT_W-1:0]        min1;
  logic [mvp_pkg::SPEED_W-1:0]          prof;
  logic [mvp_pkg::SPEED_W-1:0]          prof_mode;
  logic [mvp_pkg::SPEED_W-1:0]          speed_nxt;
  logic [mvp_pkg::DRV_PROD_W-1:0]       drv_prod;
  logic [mvp_pkg::DRV_PROD_W-1:0]       drv_raw;
  logic signed [mvp_pkg::DRIVE_W-1:0]   drv_pos;
  logic signed [mvp_pkg::DRIVE_W-1:0]   drv_neg;
  logic                                 out_load;

  // measured position: floor of the wheel mean, or the leading wheel in a spin
  assign pos_sum  = {left_r[mvp_pkg::POS_W-1], left_r} + {right_r[mvp_pkg::POS_W-1], right_r};
  assign meas_val = (mode_r == mvp_pkg::MODE_SPIN) ?
                    ((angle_r > 0) ? right_r : left_r) : pos_sum[mvp_pkg::POS_W:1];

  assign angle_abs = angle_r[mvp_pkg::ANGLE_W-1] ? mvp_pkg::ANGLE_W'(-angle_r)
                                                 : mvp_pkg::ANGLE_W'(angle_r);

  // shared multiplier operand select
  always_comb begin
    case (state_r)
      S_TGT: begin
        mul_a = mvp_pkg::MUL_A_W'(angle_abs);
        mul_b = mvp_pkg::MUL_B_W'(sep_r);
      end
      S_MULQ: begin
        mul_a = max_accel_r;
        mul_b = rem_r;
      end
      default: begin
        mul_a = mvp_pkg::MUL_A_W'(accel_tick_r);
        mul_b = mvp_pkg::MUL_B_W'(tick_r);
      end
    endcase
  end

  // remaining distance against the straight target or the spin arc
  assign target_val = (mode_r == mvp_pkg::MODE_SPIN) ?
                      mvp_pkg::WIDE_W'(prod_r >> (mvp_pkg::FRAC_BITS + 1)) :
                      mvp_pkg::WIDE_W'(target_r);
  assign rem_val = target_val - mvp_pkg::WIDE_W'(travel_r);
  assign finish  = rem_val[mvp_pkg::WIDE_W-1] || (rem_val == '0) || stop_r;

  // braking root of 2 * max_accel * remaining
  assign sq_start = (state_r == S_MULA);

  mvp_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (mvp_pkg::SQ_IN_W'({prod_r, 1'b0})),
    .done     (sq_done),
    .root     (sq_root)
  );

  // profile: min of cruise, root and ramp, halved in a spin, floored at min speed
  assign min1 = (sq_root < mvp_pkg::SQ_ROOT_W'(cruise_r)) ? sq_root
                                                          : mvp_pkg::SQ_ROOT_W'(cruise_r);
  assign prof = (prod_r < mvp_pkg::PROD_W'(min1)) ? mvp_pkg::SPEED_W'(prod_r)
                                                  : mvp_pkg::SPEED_W'(min1);
  assign prof_mode = (mode_r == mvp_pkg::MODE_SPIN) ? (prof >> 1) : prof;
  assign speed_nxt = (prof_mode < speed_floor_r) ? speed_floor_r : prof_mode;

  // drive = floor(100 * speed), saturated
  assign drv_prod = mvp_pkg::DRV_PROD_W'(speed_r) * mvp_pkg::DRV_PROD_W'(mvp_pkg::DRIVE_SCALE);
  assign drv_raw  = drv_prod >> mvp_pkg::FRAC_BITS;
  assign drv_pos  = (drv_raw > mvp_pkg::DRIVE_MAX) ? mvp_pkg::DRIVE_W'(mvp_pkg::DRIVE_MAX)
                                                   : mvp_pkg::DRIVE_W'(drv_raw);
  assign drv_neg  = mvp_pkg::DRIVE_W'(0) - drv_pos;

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_if.ready);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= mvp_pkg::MODE_STRAIGHT;
      cruise_r      <= '0;
      target_r      <= '0;
      angle_r       <= '0;
      sep_r         <= '0;
      max_accel_r   <= '0;
      accel_tick_r  <= '0;
      speed_floor_r <= '0;
    end else if (cfg_we) begin
      unique case (mvp_pkg::cfg_idx_t'(cfg_index))
        mvp_pkg::CFG_MODE:       mode_r        <= cfg_data[0];
        mvp_pkg::CFG_CRUISE:     cruise_r      <= cfg_data[mvp_pkg::SPEED_W-1:0];
        mvp_pkg::CFG_TARGET:     target_r      <= cfg_data[mvp_pkg::DIST_W-1:0];
        mvp_pkg::CFG_ANGLE:      angle_r       <= cfg_data[mvp_pkg::ANGLE_W-1:0];
        mvp_pkg::CFG_SEPARATION: sep_r         <= cfg_data[mvp_pkg::SPEED_W-1:0];
        mvp_pkg::CFG_MAX_ACCEL:  max_accel_r   <= cfg_data[mvp_pkg::ACCEL_W-1:0];
        mvp_pkg::CFG_ACCEL_TICK: accel_tick_r  <= cfg_data[mvp_pkg::SPEED_W-1:0];
        mvp_pkg::CFG_MIN_SPEED:  speed_floor_r <= cfg_data[mvp_pkg::SPEED_W-1:0];
      endcase
    end
  end

  // sequencer, move state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      start_pos_r  <= '0;
      tick_r       <= '0;
      moving_r     <= 1'b0;
      left_r       <= '0;
      right_r      <= '0;
      start_r      <= 1'b0;
      stop_r       <= 1'b0;
      meas_r       <= '0;
      travel_r     <= '0;
      rem_r        <= '0;
      prod_r       <= '0;
      speed_r      <= '0;
      pend_left_r  <= '0;
      pend_right_r <= '0;
      pend_done_r  <= 1'b0;
      out_valid_r  <= 1'b0;
      out_left_r   <= '0;
      out_right_r  <= '0;
      out_done_r   <= 1'b0;
    end else begin
      // result taken and nothing new loaded behind it
      if (out_valid_r && out_if.ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_TGT || state_r == S_MULQ || state_r == S_MULA) begin
        prod_r <= mul_a * mul_b;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_if.valid) begin
            left_r  <= in_if.left_position;
            right_r <= in_if.right_position;
            start_r <= in_if.start_req;
            stop_r  <= in_if.stop_request;
            state_r <= S_MEAS;
          end
        end
        S_MEAS: begin
          meas_r  <= meas_val;
          state_r <= S_TRAV;
        end
        S_TRAV: begin
          // a start tick latches the reference and clears the ramp
          if (start_r) begin
            start_pos_r <= meas_r;
            tick_r      <= '0;
            moving_r    <= 1'b1;
            travel_r    <= '0;
            state_r     <= S_TGT;
          end else if (moving_r) begin
            travel_r <= mvp_pkg::TRAVEL_W'(meas_r) - mvp_pkg::TRAVEL_W'(start_pos_r);
            state_r  <= S_TGT;
          end else begin
            pend_left_r  <= '0;
            pend_right_r <= '0;
            pend_done_r  <= 1'b1;
            state_r      <= S_OUT;
          end
        end
        S_TGT: begin
          state_r <= S_REM;
        end
        S_REM: begin
          if (finish) begin
            moving_r     <= 1'b0;
            pend_left_r  <= '0;
            pend_right_r <= '0;
            pend_done_r  <= 1'b1;
            state_r      <= S_OUT;
          end else begin
            rem_r   <= rem_val[mvp_pkg::REM_W-1:0];
            state_r <= S_MULQ;
          end
        end
        S_MULQ: begin
          state_r <= S_MULA;
        end
        S_MULA: begin
          // ramp product taken this cycle, then the count moves on
          if (tick_r != '1) begin
            tick_r <= tick_r + 1'b1;
          end
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_done) begin
            state_r <= S_MIN;
          end
        end
        S_MIN: begin
          speed_r <= speed_nxt;
          state_r <= S_DRV;
        end
        S_DRV: begin
          pend_done_r <= 1'b0;
          if (mode_r == mvp_pkg::MODE_SPIN) begin
            pend_left_r  <= (angle_r > 0) ? drv_neg : drv_pos;
            pend_right_r <= (angle_r > 0) ? drv_pos : drv_neg;
          end else begin
            pend_left_r  <= drv_pos;
            pend_right_r <= drv_pos;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            out_left_r  <= pend_left_r;
            out_right_r <= pend_right_r;
            out_done_r  <= pend_done_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_if.ready        = (state_r == S_IDLE) && rst_n;
  assign out_if.valid       = out_valid_r;
  assign out_if.left_drive  = out_left_r;
  assign out_if.right_drive = out_right_r;
  assign out_if.done_res    = out_done_r;

  // a new result appears only from the output state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside the output state");

  // finished or idle ticks carry zero drives
  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> (out_left_r == '0) && (out_right_r == '0))
    else $error("done result with nonzero drive");

  // a moving result leaves the move in progress
  a_moving: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid_r) && !out_done_r) |-> moving_r)
    else $error("drive result while no move in progress");

  // tick count changes only at the ramp step or a start
  a_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_MULA && state_r != S_TRAV) |=> $stable(tick_r))
    else $error("tick count changed outside its update points");

endmodule

### bench/move_velocity_profile_tb.sv
// Self-checking testbench for the move velocity profile block.
`timescale 1ns / 1ps

module move_velocity_profile_tb;
  import mvp_pkg::*;

  // Bounds the tests use for the tuning register values
  localparam int unsigned SPEED_LIM = 1048576;
  localparam int unsigned DIST_LIM  = 2147483647;
  localparam int unsigned ACCEL_LIM = 16777216;
  localparam int          ANGLE_LIM = 4194304;
  localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;
  localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam longint unsigned DRIVE_CEIL = 32767;

  localparam int DRAIN_CYCLES = 60;    // longest latency plus margin
  localparam int STALL_LIMIT  = 4000;  // cycles with no request or result moving
  localparam int MAX_REPORTS  = 10;

  // One control tick and the drive pair it produces
  typedef struct {
    logic signed [POS_W-1:0] left;
    logic signed [POS_W-1:0] right;
    logic                    start;
    logic                    stop;
  } pos_request_t;

  typedef struct {
    logic signed [DRIVE_W-1:0] left;
    logic signed [DRIVE_W-1:0] right;
    logic                      done;
  } drive_res_t;

  // Local copy of the tuning registers
  typedef struct {
    bit                      mode;
    bit [SPEED_W-1:0]        cruise;
    bit [DIST_W-1:0]         target;
    bit signed [ANGLE_W-1:0] angle;
    bit [SPEED_W-1:0]        separation;
    bit [ACCEL_W-1:0]        max_accel;
    bit [SPEED_W-1:0]        accel_tick;
    bit [SPEED_W-1:0]        speed_floor;
  } profile_regs_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mvp_in_if  req_ch ();
  mvp_out_if res_ch ();

  move_velocity_profile dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_if     (req_ch),
    .out_if    (res_ch)
  );

  // Predictor state
  profile_regs_t regs;
  longint        home_pos;
  bit [TICK_W-1:0] tick_cnt;
  bit            in_motion;

  drive_res_t expected_drives[$];
  int drive_errors;
  int ticks_sent;
  int quiet_cycles;
  int hold_off;
  bit back_to_back;

  // 125 MHz clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int roll;
    if (back_to_back) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Register value: extremes, a usual span, or anything in range
  function automatic int unsigned pick_span(int unsigned top, int unsigned usual);
    case ($urandom_range(0, 9))
      0:          return 0;
      1:          return top;
      2, 3, 4, 5: return $urandom_range(0, usual);
      default:    return $urandom_range(0, top);
    endcase
  endfunction

  // Floor square root, one result bit per pass
  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x    = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Measured position: leading wheel in a spin, floored mean otherwise
  function automatic longint measure_pos(pos_request_t q);
    longint lw;
    longint rw;
    lw = q.left;
    rw = q.right;
    if (regs.mode == MODE_SPIN) return (regs.angle > 0) ? rw : lw;
    return (lw + rw) >>> 1;
  endfunction

  // Distance to cover under the current registers
  function automatic longint move_goal();
    longint          ang;
    longint unsigned arc;
    if (regs.mode != MODE_SPIN) return regs.target;
    ang = regs.angle;
    if (ang < 0) ang = -ang;
    arc = ang;
    arc = ((arc * regs.separation) >> FRAC_BITS) >> 1;
    return arc;
  endfunction

  // Drive pair for one accepted tick; advances the move state
  function automatic drive_res_t predict_drives(pos_request_t q);
    drive_res_t      res;
    longint          left_over;
    longint unsigned rem;
    longint unsigned acc;
    longint unsigned ramp;
    longint unsigned spd;
    longint unsigned drv;
    res.left  = '0;
    res.right = '0;
    res.done  = 1'b1;
    if (q.start) begin
      home_pos  = measure_pos(q);
      tick_cnt  = '0;
      in_motion = 1'b1;
    end
    if (!in_motion) return res;

    left_over = move_goal() - (measure_pos(q) - home_pos);
    if (left_over <= 0 || q.stop) begin
      in_motion = 1'b0;
      return res;
    end
    rem = left_over;

    // min of cruise, braking root and ramp
    acc  = regs.max_accel;
    ramp = regs.accel_tick;
    ramp = ramp * tick_cnt;
    spd  = regs.cruise;
    acc  = int_sqrt(2 * acc * rem);
    if (acc < spd) spd = acc;
    if (ramp < spd) spd = ramp;
    if (tick_cnt != '1) tick_cnt++;

    if (regs.mode == MODE_SPIN) spd = spd >> 1;
    if (spd < regs.speed_floor) spd = regs.speed_floor;
    drv = (spd * DRIVE_SCALE) >> FRAC_BITS;
    if (drv > DRIVE_CEIL) drv = DRIVE_CEIL;

    res.done = 1'b0;
    if (regs.mode == MODE_SPIN && regs.angle > 0) begin
      res.left  = DRIVE_W'(0 - drv);
      res.right = DRIVE_W'(drv);
    end else if (regs.mode == MODE_SPIN) begin
      res.left  = DRIVE_W'(drv);
      res.right = DRIVE_W'(0 - drv);
    end else begin
      res.left  = DRIVE_W'(drv);
      res.right = DRIVE_W'(drv);
    end
    return res;
  endfunction

  // Register write; the block is idle whenever this is called
  task automatic write_reg(input cfg_idx_t idx, input bit [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_MODE:       regs.mode        = data[0];
      CFG_CRUISE:     regs.cruise      = data[SPEED_W-1:0];
      CFG_TARGET:     regs.target      = data[DIST_W-1:0];
      CFG_ANGLE:      regs.angle       = data[ANGLE_W-1:0];
      CFG_SEPARATION: regs.separation  = data[SPEED_W-1:0];
      CFG_MAX_ACCEL:  regs.max_accel   = data[ACCEL_W-1:0];
      CFG_ACCEL_TICK: regs.accel_tick  = data[SPEED_W-1:0];
      CFG_MIN_SPEED:  regs.speed_floor = data[SPEED_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_angle(input int ang);
    bit [ANGLE_W-1:0] bits;
    bits = ANGLE_W'(ang);
    write_reg(CFG_ANGLE, CFG_DATA_W'(bits));
  endtask

  task automatic apply_setup(input bit m, input int unsigned cruise, input int unsigned target,
                             input int ang, input int unsigned sep, input int unsigned accel,
                             input int unsigned per_tick, input int unsigned floor_spd);
    write_reg(CFG_MODE, CFG_DATA_W'(m));
    write_reg(CFG_CRUISE, CFG_DATA_W'(cruise));
    write_reg(CFG_TARGET, CFG_DATA_W'(target));
    set_angle(ang);
    write_reg(CFG_SEPARATION, CFG_DATA_W'(sep));
    write_reg(CFG_MAX_ACCEL, CFG_DATA_W'(accel));
    write_reg(CFG_ACCEL_TICK, CFG_DATA_W'(per_tick));
    write_reg(CFG_MIN_SPEED, CFG_DATA_W'(floor_spd));
  endtask

  // Offer one tick request and record its expected drives on accept
  task automatic send_tick(input logic signed [POS_W-1:0] l, input logic signed [POS_W-1:0] r,
                           input logic st, input logic sp);
    int           gap;
    pos_request_t q;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid          <= 1'b1;
    req_ch.left_position  <= l;
    req_ch.right_position <= r;
    req_ch.start_req      <= st;
    req_ch.stop_request   <= sp;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    q.left  = l;
    q.right = r;
    q.start = st;
    q.stop  = sp;
    expected_drives.push_back(predict_drives(q));
    ticks_sent++;
  endtask

  // Wait until every drive pair is back and the block has gone quiet
  task automatic settle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (expected_drives.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Idle ticks with no move: zero drives whatever the stop flag says
  task automatic test_idle_ticks();
    send_tick(POS_MAX, POS_MIN, 1'b0, 1'b1);
    send_tick('0, '0, 1'b0, 1'b0);
    send_tick(POS_MIN, POS_MAX, 1'b0, 1'b1);
  endtask

  // Straight move: floor speed, ramp, target reached, start with stop, zero cruise
  task automatic test_straight_profile();
    settle();
    apply_setup(MODE_STRAIGHT, 131072, 65536, 0, 0, ACCEL_LIM, 16384, 3277);
    send_tick(POS_MIN, POS_MAX, 1'b1, 1'b0);
    send_tick(POS_MIN + 13108, POS_MAX, 1'b0, 1'b0);
    send_tick(POS_MIN + 40000, POS_MAX, 1'b0, 1'b0);
    send_tick(POS_MIN + 100000, POS_MAX, 1'b0, 1'b0);
    send_tick(POS_MIN + 131072, POS_MAX, 1'b0, 1'b0);
    send_tick(POS_MIN + 131072, POS_MAX, 1'b0, 1'b1);
    send_tick('0, '0, 1'b1, 1'b1);
    settle();
    write_reg(CFG_CRUISE, '0);
    send_tick(100, 100, 1'b1, 1'b0);
    send_tick(200, 300, 1'b0, 1'b0);
    send_tick(POS_MAX, POS_MAX, 1'b0, 1'b0);
  endtask

  // Spin turns both ways at plus and minus ANGLE_LIM, and a zero arc
  task automatic test_spin_turns();
    settle();
    apply_setup(MODE_SPIN, SPEED_LIM, 0, ANGLE_LIM, SPEED_LIM, 65536, SPEED_LIM, 0);
    send_tick('0, '0, 1'b1, 1'b0);
    send_tick(-1000, 1000, 1'b0, 1'b0);
    send_tick(-2000, 2000, 1'b0, 1'b1);
    settle();
    set_angle(-ANGLE_LIM);
    send_tick(5000, 5000, 1'b1, 1'b0);
    send_tick(5000 + (1 << 20), '0, 1'b0, 1'b0);
    send_tick(POS_MAX, '0, 1'b0, 1'b0);
    settle();
    set_angle(0);
    send_tick('0, '0, 1'b1, 1'b0);
  endtask

  // Mode and angle changed while a move is under way keep the old reference
  task automatic test_reconfig_mid_move();
    settle();
    apply_setup(MODE_STRAIGHT, 131072, 10 << 16, 0, 65536, 65536, 8192, 1000);
    send_tick('0, '0, 1'b1, 1'b0);
    send_tick(1000, 1000, 1'b0, 1'b0);
    settle();
    write_reg(CFG_MODE, CFG_DATA_W'(MODE_SPIN));
    send_tick(-5000, 7, 1'b0, 1'b0);
    settle();
    set_angle(300000);
    send_tick(-5000, 9000, 1'b0, 1'b0);
    send_tick(-5000, 9000, 1'b0, 1'b1);
  endtask

  // Result side held off long enough that the block stalls its input
  task automatic test_output_backpressure();
    settle();
    apply_setup(MODE_STRAIGHT, 131072, 20 << 16, 0, 0, 65536, 8192, 1000);
    back_to_back = 1'b1;
    hold_off     = 400;
    send_tick('0, '0, 1'b1, 1'b0);
    for (int i = 1; i <= 16; i++) send_tick(i * 2000, i * 2000, 1'b0, 1'b0);
    back_to_back = 1'b0;
  endtask

  // One well-formed move with random content, some noise ticks mixed in
  task automatic run_move();
    logic signed [POS_W-1:0] lp;
    logic signed [POS_W-1:0] rp;
    longint span;
    longint stride;
    int     n_steps;
    int     guard;
    int     jit;
    if ($urandom_range(0, 7) == 0) begin
      lp = $urandom;
      rp = $urandom;
    end else begin
      lp = int'($urandom_range(0, 1 << 30)) - (1 << 29);
      rp = lp + int'($urandom_range(0, 2000)) - 1000;
    end
    send_tick(lp, rp, 1'b1, 1'b0);
    span    = move_goal();
    n_steps = $urandom_range(3, 24);
    guard   = 0;
    while (in_motion && guard < 40) begin
      guard++;
      if ($urandom_range(0, 9) == 0) begin
        send_tick($urandom, $urandom, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
      end else begin
        stride = span / n_steps * $urandom_range(500, 1600) / 1000 + $urandom_range(0, 255);
        jit    = int'($urandom_range(0, 200)) - 100;
        if (regs.mode == MODE_SPIN && regs.angle > 0) begin
          rp = rp + POS_W'(stride);
          lp = lp - POS_W'(stride) + jit;
        end else if (regs.mode == MODE_SPIN) begin
          lp = lp + POS_W'(stride);
          rp = rp - POS_W'(stride) + jit;
        end else begin
          lp = lp + POS_W'(stride) + jit;
          rp = rp + POS_W'(stride) - jit;
        end
        send_tick(lp, rp, $urandom_range(0, 39) == 0, $urandom_range(0, 29) == 0);
      end
    end
    if (in_motion) send_tick(lp, rp, 1'b0, 1'b1);
    repeat ($urandom_range(0, 2)) send_tick(lp, rp, 1'b0, $urandom_range(0, 1) == 1);
  endtask

  // Random register settings, a few moves under each
  task automatic test_random_moves(input int how_many);
    int stop_at;
    int ang;
    stop_at = ticks_sent + how_many;
    while (ticks_sent < stop_at) begin
      settle();
      case ($urandom_range(0, 7))
        0:       ang = -ANGLE_LIM;
        1:       ang = ANGLE_LIM;
        2:       ang = 0;
        3, 4, 5: ang = int'($urandom_range(0, 824000)) - 412000;
        default: ang = int'($urandom_range(0, 2 * ANGLE_LIM)) - ANGLE_LIM;
      endcase
      apply_setup(1'($urandom_range(0, 1)), pick_span(SPEED_LIM, 196608),
                  pick_span(DIST_LIM, 5 << 16), ang, pick_span(SPEED_LIM, 26214),
                  pick_span(ACCEL_LIM, 262144), pick_span(SPEED_LIM, 16384),
                  pick_span(SPEED_LIM, 6554));
      back_to_back = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 5)) run_move();
    end
    back_to_back = 1'b0;
  endtask

  // Result side ready, with random stalls and the long hold-off on request
  initial begin : result_ready_driver
    int stall_left;
    stall_left   = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        stall_left = hold_off;
        hold_off   = 0;
      end
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        res_ch.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Compare each drive pair with the oldest expectation
  always @(posedge clk) begin : drive_checker
    drive_res_t want;
    if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (expected_drives.size() == 0) begin
        drive_errors++;
        if (drive_errors <= MAX_REPORTS)
          $display("unexpected drive result: L=%0d R=%0d done=%0b",
                   res_ch.left_drive, res_ch.right_drive, res_ch.done_res);
      end else begin
        want = expected_drives.pop_front();
        if (res_ch.left_drive !== want.left || res_ch.right_drive !== want.right ||
            res_ch.done_res !== want.done) begin
          drive_errors++;
          if (drive_errors <= MAX_REPORTS)
            $display("drive mismatch: expected L=%0d R=%0d done=%0b, got L=%0d R=%0d done=%0b",
                     want.left, want.right, want.done,
                     res_ch.left_drive, res_ch.right_drive, res_ch.done_res);
        end
      end
    end
  end

  // Watchdog: too long with nothing moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
        (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  // Test sequence
  initial begin
    regs          = '{default: '0};
    home_pos      = 0;
    tick_cnt      = '0;
    in_motion     = 1'b0;
    drive_errors  = 0;
    ticks_sent    = 0;
    quiet_cycles  = 0;
    hold_off      = 0;
    back_to_back  = 1'b0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_MODE;
    cfg_data      = '0;
    req_ch.valid          = 1'b0;
    req_ch.left_position  = '0;
    req_ch.right_position = '0;
    req_ch.start_req      = 1'b0;
    req_ch.stop_request   = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_ticks();
    test_straight_profile();
    test_spin_turns();
    test_reconfig_mid_move();
    test_output_backpressure();
    test_random_moves(860);
    settle();

    if (drive_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
